// ----- design/heartbeat_offline_monitor_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the heartbeat offline monitor
// Shared property templates, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_OFFLINE_MONITOR_TOP_ASSERT_SVH
`define HEARTBEAT_OFFLINE_MONITOR_TOP_ASSERT_SVH

// same-cycle implication
`define HBOM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HBOM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/hbom_pkg.sv -----
// ----------------------------------------------------------------------------
// hbom_pkg
// Types, constants and helpers of the heartbeat offline monitor.
// ----------------------------------------------------------------------------
package hbom_pkg;

	localparam int CHANNELS = 12;
	localparam int CH_W     = 4;
	localparam int TS_W     = 32;
	localparam int TMO_W    = 16;
	localparam int PRIO_W   = 4;
	localparam int BLINK_W  = 3;
	localparam int TUNE_W   = 16;
	localparam int BEEP_W   = 15;
	localparam int PHASE_W  = 6;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 48;
	localparam int FLASH_MAX = 7;
	localparam int FLASH_SPACING = 6;

	localparam logic [CH_W-1:0]    NO_SEL     = CH_W'(CHANNELS);
	localparam logic [PHASE_W-1:0] PHASE_WRAP = PHASE_W'(50);

	typedef enum logic [1:0] {
		FUNC_BEAT = 2'd0,
		FUNC_TICK = 2'd1,
		FUNC_SCAN = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_TIMEOUT  = 3'd0,
		REG_ENABLE   = 3'd1,
		REG_PRIORITY = 3'd2,
		REG_BLINK    = 3'd3,
		REG_TUNE     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic                done;
		logic [CHANNELS-1:0] mask;
		logic                err;
		logic [CH_W-1:0]     sel;
	} scan_res_t;

	typedef struct packed {
		logic              led;
		logic [BEEP_W-1:0] beep;
		logic [PHASE_W-1:0] phase;
	} ind_t;

	function automatic logic [PRIO_W-1:0] chan_prio(
		input logic [CHANNELS*PRIO_W-1:0] tbl, input logic [CH_W-1:0] ch);
		logic [PRIO_W-1:0] p;
		p = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (ch == CH_W'(i))
				p = tbl[i*PRIO_W +: PRIO_W];
		end
		return p;
	endfunction

	function automatic logic [BLINK_W-1:0] chan_blinks(
		input logic [CHANNELS*BLINK_W-1:0] tbl, input logic [CH_W-1:0] ch);
		logic [BLINK_W-1:0] n;
		n = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (ch == CH_W'(i))
				n = tbl[i*BLINK_W +: BLINK_W];
		end
		return n;
	endfunction

	// flash slot 1..7 for phases 1, 7, 13, ..., 37; 0 elsewhere
	function automatic logic [BLINK_W-1:0] phase_slot(input logic [PHASE_W-1:0] p);
		logic [BLINK_W-1:0] s;
		s = '0;
		for (int j = 0; j < FLASH_MAX; j++) begin
			if (p == PHASE_W'(1 + FLASH_SPACING*j))
				s = BLINK_W'(j + 1);
		end
		return s;
	endfunction

endpackage

// ----- design/heartbeat_offline_monitor_top.sv -----
// ----------------------------------------------------------------------------
// heartbeat_offline_monitor_top
// Multi-channel heartbeat watchdog with offline selection and LED/beep flash.
//
//  Channel   Dir  Contents
//  s_axis    in   tuser = func[1:0]; tdata = channel[3:0]
//  m_axis    out  tdata = mask, error, selection, LED, beep, phase (one per scan)
//  cfg       in   cfg_we / cfg_addr / cfg_wdata register writes
//
//  Heartbeats and ticks are handled as they are accepted; a scan's length is
//  set by the one-entry-per-cycle walk of the stamp RAM read port.
//  s_axis_tready stays low while a scan runs or its item waits on a full
//  output register; heartbeats and ticks pass while a finished item waits.
//  Reset clears time, stamps (through per-entry valid bits) and indicator.
// ----------------------------------------------------------------------------
module heartbeat_offline_monitor_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // channel[3:0], zero pad
	input  logic [1:0]                    s_axis_tuser,  // func[1:0]
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// offline_mask[11:0], error_present[12], selected_channel[16:13],
	// led_red[17], beep_level[32:18], blink_phase[38:33], zero pad[39]
	output logic [39:0]                   m_axis_tdata,
	input  logic                          cfg_we,
	input  logic [hbom_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [hbom_pkg::CFG_DW-1:0]   cfg_wdata
);

`include "heartbeat_offline_monitor_top_assert.svh"

	logic [hbom_pkg::TMO_W-1:0]                     timeout_q;
	logic [hbom_pkg::CHANNELS-1:0]                  enable_q;
	logic [hbom_pkg::CHANNELS*hbom_pkg::PRIO_W-1:0] prio_q;
	logic [hbom_pkg::CHANNELS*hbom_pkg::BLINK_W-1:0] blink_q;
	logic [hbom_pkg::TUNE_W-1:0]                    tune_q;
	logic [hbom_pkg::TS_W-1:0]                      now_q;

	logic                        accept;
	hbom_pkg::func_t             func;
	logic [hbom_pkg::CH_W-1:0]   chan;
	logic                        beat_we;
	logic                        scan_start;
	logic                        busy;
	logic                        go;
	logic                        commit;
	logic                        rd_en;
	logic [hbom_pkg::CH_W-1:0]   rd_addr;
	logic [hbom_pkg::TS_W-1:0]   rd_data;
	hbom_pkg::scan_res_t         res;
	hbom_pkg::ind_t              ind;
	logic                        out_vld_q;
	logic [39:0]                 out_data_q;

	assign func   = hbom_pkg::func_t'(s_axis_tuser);
	assign chan   = s_axis_tdata[hbom_pkg::CH_W-1:0];
	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !busy;

	assign beat_we = accept && (func == hbom_pkg::FUNC_BEAT) &&
		(chan < hbom_pkg::CH_W'(hbom_pkg::CHANNELS)) && enable_q[chan];
	assign scan_start = accept && (func == hbom_pkg::FUNC_SCAN);

	assign go     = !out_vld_q || m_axis_tready;
	assign commit = res.done && go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= hbom_pkg::TMO_W'(200);
			enable_q  <= '1;
			prio_q    <= '0;
			blink_q   <= '0;
			tune_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				hbom_pkg::REG_TIMEOUT:  timeout_q <= cfg_wdata[hbom_pkg::TMO_W-1:0];
				hbom_pkg::REG_ENABLE:   enable_q  <= cfg_wdata[hbom_pkg::CHANNELS-1:0];
				hbom_pkg::REG_PRIORITY: prio_q    <= cfg_wdata[hbom_pkg::CHANNELS*hbom_pkg::PRIO_W-1:0];
				hbom_pkg::REG_BLINK:    blink_q   <= cfg_wdata[hbom_pkg::CHANNELS*hbom_pkg::BLINK_W-1:0];
				hbom_pkg::REG_TUNE:     tune_q    <= cfg_wdata[hbom_pkg::TUNE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			now_q <= '0;
		else if (accept && (func == hbom_pkg::FUNC_TICK))
			now_q <= now_q + 1'b1;
	end

	hbom_stamp_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (beat_we),
		.waddr  (chan),
		.wdata  (now_q),
		.re     (rd_en),
		.raddr  (rd_addr),
		.rdata  (rd_data)
	);

	hbom_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.go       (go),
		.now_ms   (now_q),
		.timeout  (timeout_q),
		.enable   (enable_q),
		.prio_tbl (prio_q),
		.busy     (busy),
		.re       (rd_en),
		.raddr    (rd_addr),
		.rdata    (rd_data),
		.res      (res)
	);

	hbom_indicator u_ind (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.sel       (res.sel),
		.blink_tbl (blink_q),
		.tune      (tune_q),
		.ind       (ind)
	);

	always_ff @(posedge clk) begin
		if (commit)
			out_data_q <= {1'b0, ind.phase, ind.beep, ind.led, res.sel, res.err, res.mask};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (commit)
			out_vld_q <= 1'b1;
		else if (m_axis_tready)
			out_vld_q <= 1'b0;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	`HBOM_ASSERT_NOW(a_phase_range, m_axis_tvalid, m_axis_tdata[38:33] <= hbom_pkg::PHASE_WRAP, "phase beyond wrap")
	`HBOM_ASSERT_NOW(a_noerr_nosel, m_axis_tvalid && !m_axis_tdata[12], m_axis_tdata[16:13] == hbom_pkg::NO_SEL, "selection without offline channel")
	`HBOM_ASSERT_NOW(a_err_mask, m_axis_tvalid, m_axis_tdata[12] == (m_axis_tdata[11:0] != 12'd0), "error flag disagrees with mask")
	`HBOM_ASSERT_NEXT(a_scan_busy, scan_start, !s_axis_tready, "input taken during scan")

endmodule

// ----- design/hbom_stamp_ram.sv -----
// ----------------------------------------------------------------------------
// hbom_stamp_ram
// Last-heard stamp store, one write and one registered read port.
// ----------------------------------------------------------------------------
module hbom_stamp_ram (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  we,
	input  logic [hbom_pkg::CH_W-1:0]             waddr,
	input  logic [hbom_pkg::TS_W-1:0]             wdata,
	input  logic                                  re,
	input  logic [hbom_pkg::CH_W-1:0]             raddr,
	output logic [hbom_pkg::TS_W-1:0]             rdata
);

	logic [hbom_pkg::TS_W-1:0]     mem [hbom_pkg::CHANNELS];
	logic [hbom_pkg::CHANNELS-1:0] vld_q;
	logic [hbom_pkg::TS_W-1:0]     rd_data_q;
	logic                          rd_vld_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we)
				vld_q[waddr] <= 1'b1;
			if (re)
				rd_vld_q <= vld_q[raddr];
		end
	end

	// unwritten entries read as zero
	assign rdata = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- design/hbom_scan.sv -----
// ----------------------------------------------------------------------------
// hbom_scan
// Scan sequencer: walks the stamp store, flags offline channels, selects.
// ----------------------------------------------------------------------------
module hbom_scan (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           start,
	input  logic                                           go,
	input  logic [hbom_pkg::TS_W-1:0]                      now_ms,
	input  logic [hbom_pkg::TMO_W-1:0]                     timeout,
	input  logic [hbom_pkg::CHANNELS-1:0]                  enable,
	input  logic [hbom_pkg::CHANNELS*hbom_pkg::PRIO_W-1:0] prio_tbl,
	output logic                                           busy,
	output logic                                           re,
	output logic [hbom_pkg::CH_W-1:0]                      raddr,
	input  logic [hbom_pkg::TS_W-1:0]                      rdata,
	output hbom_pkg::scan_res_t                            res
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} scan_state_t;

	scan_state_t                   state_q;
	logic [hbom_pkg::CH_W-1:0]     cnt_q;
	logic                          vld_s1;
	logic [hbom_pkg::CH_W-1:0]     idx_s1;
	logic                          vld_s2;
	logic                          off_s2;
	logic [hbom_pkg::CH_W-1:0]     idx_s2;
	logic [hbom_pkg::CHANNELS-1:0] mask_q;
	logic [hbom_pkg::PRIO_W-1:0]   best_q;
	logic [hbom_pkg::CH_W-1:0]     work_sel_q;
	logic [hbom_pkg::CH_W-1:0]     cur_sel_q;
	logic [hbom_pkg::TS_W-1:0]     delta;
	logic                          en_bit;
	logic [hbom_pkg::PRIO_W-1:0]   prio_s2;
	logic                          err;
	logic [hbom_pkg::CH_W-1:0]     sel_fin;

	assign re    = (state_q == ST_READ);
	assign raddr = cnt_q;
	assign busy  = (state_q != ST_IDLE);

	assign delta   = now_ms - rdata;
	assign en_bit  = (idx_s1 < hbom_pkg::CH_W'(hbom_pkg::CHANNELS)) && enable[idx_s1];
	assign prio_s2 = hbom_pkg::chan_prio(prio_tbl, idx_s2);

	assign err     = (mask_q != '0);
	assign sel_fin = err ? work_sel_q : hbom_pkg::NO_SEL;

	always_comb begin
		res.done = (state_q == ST_DONE);
		res.mask = mask_q;
		res.err  = err;
		res.sel  = sel_fin;
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		off_s2 <= en_bit && (delta > hbom_pkg::TS_W'(timeout));
		idx_s2 <= idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			mask_q     <= '0;
			best_q     <= '0;
			work_sel_q <= hbom_pkg::NO_SEL;
			cur_sel_q  <= hbom_pkg::NO_SEL;
		end else begin
			vld_s1 <= re;
			vld_s2 <= vld_s1;
			// accumulate one channel per cycle
			if (vld_s2 && off_s2) begin
				mask_q <= mask_q | (hbom_pkg::CHANNELS'(1) << idx_s2);
				if (prio_s2 > best_q) begin
					best_q     <= prio_s2;
					work_sel_q <= idx_s2;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q    <= ST_READ;
						cnt_q      <= '0;
						mask_q     <= '0;
						best_q     <= '0;
						work_sel_q <= cur_sel_q;
					end
				end
				ST_READ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == hbom_pkg::CH_W'(hbom_pkg::CHANNELS - 1))
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (go) begin
						cur_sel_q <= sel_fin;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- design/hbom_indicator.sv -----
// ----------------------------------------------------------------------------
// hbom_indicator
// Blink phase counter, red LED level and beep drive.
// ----------------------------------------------------------------------------
module hbom_indicator (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            commit,
	input  logic [hbom_pkg::CH_W-1:0]                       sel,
	input  logic [hbom_pkg::CHANNELS*hbom_pkg::BLINK_W-1:0] blink_tbl,
	input  logic [hbom_pkg::TUNE_W-1:0]                     tune,
	output hbom_pkg::ind_t                                  ind
);

	logic [hbom_pkg::PHASE_W-1:0] phase_q;
	logic                         red_q;
	logic                         active;
	logic [hbom_pkg::BLINK_W-1:0] n;
	logic [hbom_pkg::BLINK_W-1:0] slot;
	logic [hbom_pkg::PHASE_W-1:0] phase_nx;
	logic                         flash;

	assign active = (sel != hbom_pkg::NO_SEL);
	assign n      = hbom_pkg::chan_blinks(blink_tbl, sel);

	always_comb begin
		if (!active)
			phase_nx = phase_q;
		else if (phase_q >= hbom_pkg::PHASE_WRAP)
			phase_nx = '0;
		else
			phase_nx = phase_q + 1'b1;
	end

	assign slot  = hbom_pkg::phase_slot(phase_nx);
	assign flash = (slot != '0) && (slot <= n);

	always_comb begin
		ind.phase = phase_nx;
		ind.led   = active ? ((n == '0) || flash) : red_q;
		ind.beep  = (active && (n != '0) && flash) ? tune[hbom_pkg::TUNE_W-1:1] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			red_q   <= 1'b0;
		end else if (commit) begin
			phase_q <= phase_nx;
			red_q   <= ind.led;
		end
	end

endmodule
